FILE: sv/rtc_local_time_adjust_defines.svh
// Assertion macros used by the local time adjust top level.
`ifndef RTC_LOCAL_TIME_ADJUST_DEFINES_SVH
`define RTC_LOCAL_TIME_ADJUST_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLA_ASSERT(lbl, prop, msg)
`define RLA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: sv/rla_pkg.sv
// Types, constants and month table for the local time adjust block.
package rla_pkg;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } reading_t;

    typedef struct packed {
        logic [31:0] offset;
        logic        dst;
    } cfg_t;

    typedef struct packed {
        logic [31:0] secs;
        logic        byp;
        reading_t    rd;
    } secs_t;

    localparam logic [2:0] REG_OFFSET = 3'd0;
    localparam logic [2:0] REG_DST    = 3'd4;

    // Day count of the year term when the March-based year wraps below zero.
    localparam logic [31:0] Y_WRAP_DAYS  = 32'd1041529204;
    localparam logic [31:0] DAYS_TO_1970 = 32'd719561;
    localparam logic [11:0] DST_FROM     = 12'h31C;
    localparam logic [11:0] DST_UNTIL    = 12'hA1C;

    // 30*m + 3*(m+1)/5 with January and February counted as months 13 and 14.
    function automatic logic [8:0] month_days(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd367;
            4'd1:    r = 9'd398;
            4'd2:    r = 9'd429;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd123;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd276;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd398;
            4'd14:   r = 9'd429;
            default: r = 9'd459;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/rla_in_if.sv
// Handshake channel carrying one UTC calendar reading.
interface rla_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [2:0]  in_weekday;

    modport source(output valid, in_year, in_month, in_day, in_hour, in_minute, in_second,
                   in_weekday, input ready);
    modport sink(input valid, in_year, in_month, in_day, in_hour, in_minute, in_second,
                 in_weekday, output ready);
endinterface

FILE: sv/rla_out_if.sv
// Handshake channel carrying one adjusted local calendar reading.
interface rla_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [2:0]  out_weekday;

    modport source(output valid, out_year, out_month, out_day, out_hour, out_minute,
                   out_second, out_weekday, input ready);
    modport sink(input valid, out_year, out_month, out_day, out_hour, out_minute,
                 out_second, out_weekday, output ready);
endinterface

FILE: sv/rtc_local_time_adjust.sv
// Top level of the RTC local time adjust pipeline.
//
//   channel    dir  handshake      contents
//   reading    in   valid/ready    UTC year, month, day, hour, minute, second, weekday
//   adjusted   out  valid/ready    local year, month, day, hour, minute, second, weekday
//   apb        in   psel/penable   UTC offset (0x0), DST enable (0x4)
//
// From its transfer to its result a reading passes three stages that form the
// seconds count and seven more that split it back into a date, the last one being the
// output register. One reading enters per cycle while no result is held. Reset clears only
// the stage valid bits and the APB registers. When a result is held the whole pipeline
// holds and reading.ready goes low in the same cycle.
`include "rtc_local_time_adjust_defines.svh"
module rtc_local_time_adjust (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rla_in_if.sink      reading,
    rla_out_if.source   adjusted
);
    rla_pkg::cfg_t     cfg;
    rla_pkg::reading_t in_rd, out_rd;
    rla_pkg::secs_t    secs;
    logic              secs_valid;
    logic              out_valid, out_byp;
    logic              en;

    assign en = !out_valid || adjusted.ready;

    rla_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_rd.year    = reading.in_year;
    assign in_rd.month   = reading.in_month;
    assign in_rd.day     = reading.in_day;
    assign in_rd.hour    = reading.in_hour;
    assign in_rd.minute  = reading.in_minute;
    assign in_rd.second  = reading.in_second;
    assign in_rd.weekday = reading.in_weekday;
    assign reading.ready = en;

    rla_to_secs u_to_secs (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (reading.valid),
        .in_rd     (in_rd),
        .cfg       (cfg),
        .out_valid (secs_valid),
        .out_data  (secs)
    );

    rla_to_civil u_to_civil (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (secs_valid),
        .in_data   (secs),
        .out_valid (out_valid),
        .out_byp   (out_byp),
        .out_rd    (out_rd)
    );

    assign adjusted.valid       = out_valid;
    assign adjusted.out_year    = out_rd.year;
    assign adjusted.out_month   = out_rd.month;
    assign adjusted.out_day     = out_rd.day;
    assign adjusted.out_hour    = out_rd.hour;
    assign adjusted.out_minute  = out_rd.minute;
    assign adjusted.out_second  = out_rd.second;
    assign adjusted.out_weekday = out_rd.weekday;

    `RLA_ASSERT(a_stall_blocks_input, (out_valid && !adjusted.ready) |-> !reading.ready, "input accepted while result stalled")
    `RLA_ASSERT(a_weekday_range, (out_valid && !out_byp) |-> (out_rd.weekday != 3'd0), "converted weekday is zero")
    `RLA_ASSERT(a_month_range, (out_valid && !out_byp) |-> (out_rd.month != 4'd0 && out_rd.month <= 4'd12), "converted month out of range")
    `RLA_ASSERT(a_hour_range, (out_valid && !out_byp) |-> (out_rd.hour <= 5'd23), "converted hour out of range")
    `RLA_ASSERT_RST(a_reset_idle, !rst_n |-> !adjusted.valid, "result valid during reset")
endmodule

FILE: sv/rla_regs.sv
// APB register file holding the UTC offset and the DST enable.
module rla_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rla_pkg::cfg_t       cfg
);
    logic [31:0] offset_reg;
    logic        dst_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            dst_reg    <= 1'b0;
        end
        else if (wr)
        begin
            if (paddr[2] == rla_pkg::REG_DST[2])
                dst_reg <= pwdata[0];
            else
                offset_reg <= pwdata;
        end
    end

    assign prdata     = (paddr[2] == rla_pkg::REG_DST[2]) ? {31'd0, dst_reg} : offset_reg;
    assign cfg.offset = offset_reg;
    assign cfg.dst    = dst_reg;
endmodule

FILE: sv/rla_to_secs.sv
// Three stages turning a calendar reading into adjusted seconds since 1970.
module rla_to_secs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rla_pkg::reading_t in_rd,
    input  rla_pkg::cfg_t     cfg,
    output logic              out_valid,
    output rla_pkg::secs_t    out_data
);
    logic              v1_reg, v2_reg, v3_reg;
    logic [31:0]       ydays1_reg;
    logic [9:0]        mdd1_reg;
    logic [16:0]       hms1_reg, hms2_reg;
    logic              dst1_reg, dst2_reg;
    logic              byp1_reg, byp2_reg, byp3_reg;
    rla_pkg::reading_t rd1_reg, rd2_reg, rd3_reg;
    logic [31:0]       days2_reg, secs3_reg;

    logic [11:0] ya;
    logic        wrap;
    logic [24:0] yp;
    logic [5:0]  q100;
    logic [20:0] yd_small;
    logic [31:0] ydays_next;
    logic [9:0]  mdd_next;
    logic [16:0] hms_next;
    logic [11:0] md;
    logic        dst_next;
    logic [31:0] days_next, secs_next;

    always_comb
    begin
        wrap = (in_rd.month < 4'd3) && (in_rd.year == 12'd0);
        ya   = (in_rd.month < 4'd3) ? in_rd.year - 12'd1 : in_rd.year;
        // Exact y/100 for 12-bit years by reciprocal multiply.
        yp   = 25'(ya) * 25'd5243;
        q100 = yp[24:19];
        yd_small = 21'd365 * 21'(ya) + 21'(ya[11:2]) - 21'(q100) + 21'(q100[5:2]);
        ydays_next = wrap ? rla_pkg::Y_WRAP_DAYS : 32'(yd_small);
        mdd_next = 10'(rla_pkg::month_days(in_rd.month)) + 10'(in_rd.day);
        hms_next = 17'd3600 * 17'(in_rd.hour) + 17'd60 * 17'(in_rd.minute)
                   + 17'(in_rd.second);
        md       = {in_rd.month, 3'b000, in_rd.day};
        dst_next = cfg.dst && (md >= rla_pkg::DST_FROM) && (md < rla_pkg::DST_UNTIL);
        days_next = ydays1_reg + 32'(mdd1_reg) - rla_pkg::DAYS_TO_1970;
        secs_next = 32'(days2_reg * 32'd86400) + 32'(hms2_reg) + cfg.offset
                    + (dst2_reg ? 32'd3600 : 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ydays1_reg <= ydays_next;
            mdd1_reg   <= mdd_next;
            hms1_reg   <= hms_next;
            dst1_reg   <= dst_next;
            byp1_reg   <= (cfg.offset == 32'd0);
            rd1_reg    <= in_rd;
            days2_reg  <= days_next;
            hms2_reg   <= hms1_reg;
            dst2_reg   <= dst1_reg;
            byp2_reg   <= byp1_reg;
            rd2_reg    <= rd1_reg;
            secs3_reg  <= secs_next;
            byp3_reg   <= byp2_reg;
            rd3_reg    <= rd2_reg;
        end
    end

    assign out_valid     = v3_reg;
    assign out_data.secs = secs3_reg;
    assign out_data.byp  = byp3_reg;
    assign out_data.rd   = rd3_reg;
endmodule

FILE: sv/rla_to_civil.sv
// Seven stages turning seconds since 1970 back into a civil date and weekday.
module rla_to_civil (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rla_pkg::secs_t    in_data,
    output logic              out_valid,
    output logic              out_byp,
    output rla_pkg::reading_t out_rd
);
    logic [6:0]        v_reg;
    logic [6:0]        byp_reg;
    rla_pkg::reading_t rd4_reg, rd5_reg, rd6_reg, rd7_reg, rd8_reg, rd9_reg, out_reg;

    logic [26:0] q1_reg;
    logic [5:0]  ss4_reg, ss5_reg, ss6_reg, ss7_reg, ss8_reg, ss9_reg;
    logic [20:0] q2_reg;
    logic [5:0]  mm5_reg, mm6_reg, mm7_reg, mm8_reg, mm9_reg;
    logic [15:0] days_reg;
    logic [4:0]  hh6_reg, hh7_reg, hh8_reg, hh9_reg;
    logic [21:0] jd7_reg, jd8_reg;
    logic [2:0]  wd7_reg, wd8_reg, wd9_reg;
    logic [13:0] y8_reg, y9_reg;
    logic [9:0]  ed_reg;
    logic [4:0]  mq_reg;

    logic [60:0] p4;
    logic [31:0] r4;
    logic [50:0] p5;
    logic [26:0] r5;
    logic [36:0] p6;
    logic [20:0] r6;
    logic [18:0] x7;
    logic [4:0]  a7;
    logic [15:0] w7, r7;
    logic [32:0] p7;
    logic [2:0]  wd_next;
    logic [25:0] z8;
    logic [52:0] p8;
    logic [21:0] ed22;
    logic [39:0] p9;
    logic [28:0] p10;
    logic [9:0]  d10;
    rla_pkg::reading_t civ;

    always_comb
    begin
        // t / 60 as (t >> 2) / 15, exact for 30-bit operands.
        p4 = 61'(in_data.secs[31:2]) * 61'd1145324613;
        r4 = in_data.secs - 32'(p4[60:34]) * 32'd60;
        p5 = 51'(q1_reg[26:2]) * 51'd35791395;
        r5 = q1_reg - 27'(p5[49:29]) * 27'd60;
        // Hours to days as (h >> 3) / 3.
        p6 = 37'(q2_reg[20:3]) * 37'd349526;
        r6 = q2_reg - 21'(p6[35:20]) * 21'd24;

        // The century correction term a is 15, 16 or 17 over the covered span.
        x7 = {1'b0, days_reg, 2'b00} + 19'd102032;
        a7 = 5'd15 + 5'(x7 >= 19'd146097) + 5'(x7 >= 19'd292194);
        w7 = days_reg + 16'd4;
        p7 = 33'(w7) * 33'd74899;
        r7 = w7 - 16'(p7[32:19]) * 16'd7;
        wd_next = (r7[2:0] == 3'd0) ? 3'd7 : r7[2:0];

        z8 = 26'(jd7_reg) * 26'd20 - 26'd2442;
        p8 = 53'(z8) * 53'd75257470;

        ed22 = jd8_reg - 22'(y8_reg) * 22'd365 - 22'(y8_reg[13:2]);
        // ed * 1000 / 30601 folded into one constant.
        p9 = 40'(ed22[9:0]) * 40'd561416000;

        p10 = 29'(mq_reg) * 29'd10083578;
        d10 = ed_reg - 10'(mq_reg) * 10'd30 - 10'(p10[28:24]);

        civ.hour    = hh9_reg;
        civ.minute  = mm9_reg;
        civ.second  = ss9_reg;
        civ.weekday = wd9_reg;
        civ.day     = d10[4:0];
        if (mq_reg < 5'd14)
        begin
            civ.year  = 12'(y9_reg - 14'd4716);
            civ.month = 4'(mq_reg - 5'd1);
        end
        else
        begin
            civ.year  = 12'(y9_reg - 14'd4715);
            civ.month = 4'(mq_reg - 5'd13);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            byp_reg <= {byp_reg[5:0], in_data.byp};
            rd4_reg <= in_data.rd;
            rd5_reg <= rd4_reg;
            rd6_reg <= rd5_reg;
            rd7_reg <= rd6_reg;
            rd8_reg <= rd7_reg;
            rd9_reg <= rd8_reg;

            q1_reg  <= p4[60:34];
            ss4_reg <= r4[5:0];

            q2_reg  <= p5[49:29];
            mm5_reg <= r5[5:0];
            ss5_reg <= ss4_reg;

            days_reg <= p6[35:20];
            hh6_reg  <= r6[4:0];
            mm6_reg  <= mm5_reg;
            ss6_reg  <= ss5_reg;

            jd7_reg <= 22'(days_reg) + 22'd2442113 + 22'(a7) - 22'(a7[4:2]);
            wd7_reg <= wd_next;
            hh7_reg <= hh6_reg;
            mm7_reg <= mm6_reg;
            ss7_reg <= ss6_reg;

            y8_reg  <= p8[52:39];
            jd8_reg <= jd7_reg;
            wd8_reg <= wd7_reg;
            hh8_reg <= hh7_reg;
            mm8_reg <= mm7_reg;
            ss8_reg <= ss7_reg;

            ed_reg  <= ed22[9:0];
            mq_reg  <= p9[38:34];
            y9_reg  <= y8_reg;
            wd9_reg <= wd8_reg;
            hh9_reg <= hh8_reg;
            mm9_reg <= mm8_reg;
            ss9_reg <= ss8_reg;

            out_reg <= byp_reg[5] ? rd9_reg : civ;
        end
    end

    assign out_valid = v_reg[6];
    assign out_byp   = byp_reg[6];
    assign out_rd    = out_reg;
endmodule

FILE: tb/sv/rtc_local_time_adjust_checker.sv
// Checker that predicts and compares adjusted readings for the local time adjust block.
module rtc_local_time_adjust_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] offset_cfg,
    input  logic        dst_cfg,
    rla_in_if.sink      reading,
    rla_out_if.sink     adjusted,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);
    rla_pkg::reading_t local_queue[$];

    function automatic logic [31:0] to_unix_seconds(input rla_pkg::reading_t r);
        logic [31:0] y, m, days;
        y = 32'(r.year);
        m = 32'(r.month);
        if (m < 3)
        begin
            m = m + 12;
            y = y - 1;
        end
        days = 32'd365 * y + (y >> 2) - y / 100 + y / 400;
        days = days + 32'd30 * m + (32'd3 * (m + 1)) / 5 + 32'(r.day);
        days = days - 32'd719561;
        return days * 32'd86400 + 32'd3600 * 32'(r.hour) + 32'd60 * 32'(r.minute)
            + 32'(r.second);
    endfunction

    function automatic rla_pkg::reading_t to_local_time(input rla_pkg::reading_t r,
                                                        input logic [31:0] off,
                                                        input logic dst);
        rla_pkg::reading_t o;
        logic [31:0] t, days, jd, y, ed, m, d, wd;
        logic [63:0] a;
        logic [11:0] md;
        if (off == 0)
            return r;
        t = to_unix_seconds(r) + off;
        md = {4'(r.month), 3'b0, r.day};
        md = (12'(r.month) << 8) | 12'(r.day);
        if (dst && md >= 12'h31C && md < 12'hA1C)
            t = t + 32'd3600;
        o.second = 6'(t % 60);
        t = t / 60;
        o.minute = 6'(t % 60);
        t = t / 60;
        o.hour = 5'(t % 24);
        days = t / 24;
        a = (64'd4 * 64'(days) + 64'd102032) / 64'd146097 + 64'd15;
        jd = 32'(64'(days) + 64'd2442113 + a - (a >> 2));
        y = (32'd20 * jd - 32'd2442) / 32'd7305;
        ed = jd - 32'd365 * y - (y >> 2);
        m = ed * 32'd1000 / 32'd30601;
        d = ed - m * 32'd30 - m * 32'd601 / 32'd1000;
        if (m < 14)
        begin
            y = y - 4716;
            m = m - 1;
        end
        else
        begin
            y = y - 4715;
            m = m - 13;
        end
        wd = (days + 4) % 7;
        if (wd == 0)
            wd = 7;
        o.year = 12'(y);
        o.month = 4'(m);
        o.day = 5'(d);
        o.weekday = 3'(wd);
        return o;
    endfunction

    assign pending_count = local_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        rla_pkg::reading_t r, e;
        if (!rst_n)
        begin
            fail_count <= 0;
            checked_count <= 0;
            local_queue.delete();
        end
        else
        begin
            if (reading.valid && reading.ready)
            begin
                r = '{reading.in_year, reading.in_month, reading.in_day, reading.in_hour,
                      reading.in_minute, reading.in_second, reading.in_weekday};
                local_queue.push_back(to_local_time(r, offset_cfg, dst_cfg));
            end
            if (adjusted.valid && adjusted.ready)
            begin
                checked_count <= checked_count + 1;
                if (local_queue.size() == 0)
                begin
                    $error("unexpected adjusted transfer");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = local_queue.pop_front();
                    if (adjusted.out_year !== e.year || adjusted.out_month !== e.month ||
                        adjusted.out_day !== e.day || adjusted.out_hour !== e.hour ||
                        adjusted.out_minute !== e.minute ||
                        adjusted.out_second !== e.second ||
                        adjusted.out_weekday !== e.weekday)
                        fail_count <= fail_count + 1;
                    if (adjusted.out_year !== e.year)
                        $error("out_year expected %0d actual %0d", e.year, adjusted.out_year);
                    if (adjusted.out_month !== e.month)
                        $error("out_month expected %0d actual %0d", e.month,
                               adjusted.out_month);
                    if (adjusted.out_day !== e.day)
                        $error("out_day expected %0d actual %0d", e.day, adjusted.out_day);
                    if (adjusted.out_hour !== e.hour)
                        $error("out_hour expected %0d actual %0d", e.hour, adjusted.out_hour);
                    if (adjusted.out_minute !== e.minute)
                        $error("out_minute expected %0d actual %0d", e.minute,
                               adjusted.out_minute);
                    if (adjusted.out_second !== e.second)
                        $error("out_second expected %0d actual %0d", e.second,
                               adjusted.out_second);
                    if (adjusted.out_weekday !== e.weekday)
                        $error("out_weekday expected %0d actual %0d", e.weekday,
                               adjusted.out_weekday);
                end
            end
        end
    end
endmodule

FILE: tb/sv/rtc_local_time_adjust_tb.sv
// Top of the local time adjust testbench: stimulus, register writes and verdict.
module rtc_local_time_adjust_tb;
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic [31:0] offset_shadow;
    logic        dst_shadow;
    logic        hold_off;
    int          fail_count;
    int          pending_count;
    int          checked_count;
    int          sent_count;

    rla_in_if  reading();
    rla_out_if adjusted();

    rtc_local_time_adjust DUT (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .reading(reading.sink), .adjusted(adjusted.source)
    );

    rtc_local_time_adjust_checker u_checker (
        .clk(clk), .rst_n(rst_n), .offset_cfg(offset_shadow), .dst_cfg(dst_shadow),
        .reading(reading.sink), .adjusted(adjusted.sink), .fail_count(fail_count),
        .pending_count(pending_count), .checked_count(checked_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("rtc_local_time_adjust_tb: FAIL");
        $finish;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Receiver: random stalls, plus one long hold-off requested by the stimulus.
    initial
    begin
        int n;
        adjusted.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                adjusted.ready <= 0;
                repeat (60) @(posedge clk);
                hold_off = 0;
            end
            n = gap_length();
            if (n > 0)
            begin
                adjusted.ready <= 0;
                repeat (n) @(posedge clk);
            end
            adjusted.ready <= 1;
        end
    end

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == rla_pkg::REG_OFFSET)
            offset_shadow = data;
        else
            dst_shadow = data[0];
    endtask

    task automatic drain_results();
        while (pending_count != 0)
            @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic send_reading(input rla_pkg::reading_t r, input logic may_gap);
        int n;
        n = may_gap ? gap_length() : 0;
        if (n > 0)
        begin
            reading.valid <= 0;
            repeat (n) @(posedge clk);
        end
        reading.valid <= 1;
        {reading.in_year, reading.in_month, reading.in_day, reading.in_hour,
         reading.in_minute, reading.in_second, reading.in_weekday} <= r;
        do
            @(posedge clk);
        while (!reading.ready);
        sent_count++;
    endtask

    function automatic rla_pkg::reading_t random_reading();
        rla_pkg::reading_t r;
        r = rla_pkg::reading_t'(41'({$urandom, $urandom}));
        if ($urandom_range(0, 9) != 0)
        begin
            r.year = 12'($urandom_range(2000, 2127));
            r.month = 4'($urandom_range(1, 12));
            r.day = 5'($urandom_range(1, 31));
            r.hour = 5'($urandom_range(0, 23));
            r.minute = 6'($urandom_range(0, 59));
            r.second = 6'($urandom_range(0, 59));
            r.weekday = 3'($urandom_range(1, 7));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            r.month = ($urandom_range(0, 1) == 0) ? 4'd3 : 4'd10;
            r.day = 5'($urandom_range(26, 29));
        end
        return r;
    endfunction

    initial
    begin
        logic [31:0] offsets[8];
        rla_pkg::reading_t r;
        offsets = '{32'd0, 32'h7FFFFFFF, 32'h80000000, 32'd3600, -32'd3600, 32'd1,
                    32'hFFFFFFFF, 32'd19800};
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        hold_off = 0;
        sent_count = 0;
        offset_shadow = 0;
        dst_shadow = 0;
        reading.valid = 0;
        {reading.in_year, reading.in_month, reading.in_day, reading.in_hour,
         reading.in_minute, reading.in_second, reading.in_weekday} = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // Directed part at reset values, then with a real offset and DST.
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
            begin
                write_register(rla_pkg::REG_OFFSET, 32'd7200);
                write_register(rla_pkg::REG_DST, 32'd1);
            end
            send_reading('{12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd6}, 0);
            send_reading('{12'd2127, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd7}, 0);
            send_reading('{12'd2024, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30, 3'd4}, 0);
            send_reading('{12'd2024, 4'd3, 5'd27, 5'd23, 6'd59, 6'd59, 3'd3}, 0);
            send_reading('{12'd2024, 4'd3, 5'd28, 5'd0, 6'd0, 6'd0, 3'd4}, 0);
            send_reading('{12'd2024, 4'd10, 5'd27, 5'd23, 6'd0, 6'd0, 3'd7}, 0);
            send_reading('{12'd2024, 4'd10, 5'd28, 5'd0, 6'd0, 6'd0, 3'd1}, 0);
            send_reading('{12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 3'h7}, 0);
            send_reading('{12'h0, 4'h0, 5'h0, 5'h0, 6'h0, 6'h0, 3'h0}, 0);
            reading.valid <= 0;
            drain_results();
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            write_register(rla_pkg::REG_OFFSET, (phase == 7) ? $urandom : offsets[phase]);
            write_register(rla_pkg::REG_DST, 32'(phase % 2));
            for (int i = 0; i < 135; i++)
            begin
                if (phase == 2 && i == 20)
                    hold_off = 1;
                if (phase == 4 && i == 60)
                begin
                    reading.valid <= 0;
                    drain_results();
                end
                r = random_reading();
                send_reading(r, phase != 5);
            end
            reading.valid <= 0;
            drain_results();
        end

        $display("Sent %0d readings and checked %0d results over eight offset/DST settings.",
                 sent_count, checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("rtc_local_time_adjust_tb: PASS");
        else
            $display("rtc_local_time_adjust_tb: FAIL");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/rla_pkg.sv
sv/rla_in_if.sv
sv/rla_out_if.sv
sv/rla_regs.sv
sv/rla_to_secs.sv
sv/rla_to_civil.sv
sv/rtc_local_time_adjust.sv
tb/sv/rtc_local_time_adjust_checker.sv
tb/sv/rtc_local_time_adjust_tb.sv
